### sv/pse_pkg.sv
// shared types, codes and constants of the postfix stack evaluator
package pse_pkg;

  localparam int unsigned DATA_W          = 32;
  localparam int unsigned ACT_W           = 3;
  localparam int unsigned STAT_W          = 3;
  localparam int unsigned LIMIT_W         = 7;
  localparam int unsigned STACK_DEPTH_DEF = 64;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd50;

  typedef logic [ACT_W-1:0]  action_t;
  typedef logic [STAT_W-1:0] status_t;
  typedef logic [DATA_W-1:0] word_t;

  localparam action_t ACT_PUSH = 3'd0;
  localparam action_t ACT_ADD  = 3'd1;
  localparam action_t ACT_SUB  = 3'd2;
  localparam action_t ACT_MUL  = 3'd3;
  localparam action_t ACT_DIV  = 3'd4;

  localparam status_t ST_OK        = 3'd0;
  localparam status_t ST_UNDERFLOW = 3'd1;
  localparam status_t ST_DIVZERO   = 3'd2;
  localparam status_t ST_IGNORED   = 3'd3;
  localparam status_t ST_FINAL_OK  = 3'd4;
  localparam status_t ST_FINAL_BAD = 3'd5;

  typedef struct packed {
    logic    start;
    action_t op;
  } alu_req_t;

  typedef struct packed {
    logic  done;
    word_t result;
  } alu_rsp_t;

endpackage

### sv/pse_in_if.sv
// token channel interface
interface pse_in_if;
  logic                        valid;
  logic                        ready;
  logic [pse_pkg::ACT_W-1:0]   action;
  logic signed [pse_pkg::DATA_W-1:0] operand;
  logic                        last;

  modport source (output valid, action, operand, last, input ready);
  modport sink (input valid, action, operand, last, output ready);
endinterface

### sv/pse_out_if.sv
// result channel interface
interface pse_out_if;
  logic                        valid;
  logic                        ready;
  logic [pse_pkg::STAT_W-1:0]  status;
  logic signed [pse_pkg::DATA_W-1:0] value;
  logic                        push_refused;
  logic                        done_res;

  modport source (output valid, status, value, push_refused, done_res, input ready);
  modport sink (input valid, status, value, push_refused, done_res, output ready);
endinterface

### sv/pse_alu.sv
// iterative arithmetic unit: one shared adder for add, sub, shift-add multiply, restoring divide
module pse_alu (
  input  logic              clk,
  input  logic              rst,
  input  pse_pkg::alu_req_t req,
  input  pse_pkg::word_t    a,
  input  pse_pkg::word_t    b,
  output pse_pkg::alu_rsp_t rsp
);
  import pse_pkg::*;

  localparam int unsigned STEP_W = $clog2(DATA_W);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DATA_W - 1);

  typedef enum logic [1:0] {A_IDLE, A_RUN, A_FIX} alu_state_t;

  alu_state_t        state;
  action_t           op;
  word_t             acc;
  word_t             mcand;
  word_t             mplier;
  logic              neg;
  logic [STEP_W-1:0] step;

  logic [DATA_W:0]   add_x;
  logic [DATA_W:0]   add_y;
  logic              add_cin;
  logic [DATA_W+1:0] sum;
  word_t             quo_next;

  always_comb begin
    add_x   = '0;
    add_y   = '0;
    add_cin = 1'b0;
    case (state)
      A_IDLE: begin
        add_x   = {1'b0, a};
        add_y   = (req.op == ACT_SUB) ? {1'b0, ~b} : {1'b0, b};
        add_cin = (req.op == ACT_SUB);
      end
      A_RUN: begin
        if (op == ACT_MUL) begin
          add_x = {1'b0, acc};
          add_y = mplier[0] ? {1'b0, mcand} : '0;
        end else begin
          add_x   = {acc, mplier[DATA_W-1]};
          add_y   = ~{1'b0, mcand};
          add_cin = 1'b1;
        end
      end
      A_FIX: begin
        add_y   = {1'b0, ~mplier};
        add_cin = 1'b1;
      end
      default: ;
    endcase
    sum      = {1'b0, add_x} + {1'b0, add_y} + (DATA_W+2)'(add_cin);
    quo_next = {mplier[DATA_W-2:0], sum[DATA_W+1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= A_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      case (state)
        A_IDLE: begin
          if (req.start) begin
            op   <= req.op;
            step <= '0;
            acc  <= '0;
            case (req.op)
              ACT_ADD, ACT_SUB: begin
                rsp.result <= sum[DATA_W-1:0];
                rsp.done   <= 1'b1;
              end
              ACT_MUL: begin
                mcand  <= a;
                mplier <= b;
                state  <= A_RUN;
              end
              default: begin
                mcand  <= b[DATA_W-1] ? (~b + 1'b1) : b;
                mplier <= a[DATA_W-1] ? (~a + 1'b1) : a;
                neg    <= a[DATA_W-1] ^ b[DATA_W-1];
                state  <= A_RUN;
              end
            endcase
          end
        end
        A_RUN: begin
          step <= step + 1'b1;
          if (op == ACT_MUL) begin
            acc    <= sum[DATA_W-1:0];
            mcand  <= {mcand[DATA_W-2:0], 1'b0};
            mplier <= {1'b0, mplier[DATA_W-1:1]};
            if (step == STEP_LAST) begin
              rsp.result <= sum[DATA_W-1:0];
              rsp.done   <= 1'b1;
              state      <= A_IDLE;
            end
          end else begin
            acc    <= sum[DATA_W+1] ? sum[DATA_W-1:0] : {acc[DATA_W-2:0], mplier[DATA_W-1]};
            mplier <= quo_next;
            if (step == STEP_LAST) begin
              if (neg) begin
                state <= A_FIX;
              end else begin
                rsp.result <= quo_next;
                rsp.done   <= 1'b1;
                state      <= A_IDLE;
              end
            end
          end
        end
        A_FIX: begin
          rsp.result <= sum[DATA_W-1:0];
          rsp.done   <= 1'b1;
          state      <= A_IDLE;
        end
        default: state <= A_IDLE;
      endcase
    end
  end

endmodule

### sv/postfix_stack_evaluator_top.sv
// postfix stack evaluator top level: token sequencer, operand stack memory, result register
//
//  channel  | dir | handshake     | payload
//  in_ch    | in  | valid/ready   | action, operand, last
//  out_ch   | out | valid/ready   | status, value, push_refused, done_res
//  cfg      | in  | cfg_we        | cfg_wdata (stack_limit)
//
// push, ignored and underflow tokens go straight to finish and emit; an operator first reads
// both operands, then runs the shared unit unless the divisor is zero; multiply and divide run
//   the 32 bit-steps of the unit, a negated quotient adds a fix step; a last token on a non-empty stack reads the top
// stack reads go through one registered memory port, two reads per operator
// rst is synchronous: clears the stack count, abort flag and output valid, limit back to 50
// a new token is taken once the previous result sits in the output register

module postfix_stack_evaluator_top #(
  parameter int unsigned STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [pse_pkg::LIMIT_W-1:0]  cfg_wdata,
  pse_in_if.sink                       in_ch,
  pse_out_if.source                    out_ch
);
  import pse_pkg::*;

  localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW    = $clog2(STACK_DEPTH);
  localparam int unsigned CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

  typedef enum logic [2:0] {
    S_IDLE, S_RD1, S_RD2, S_EXEC, S_WAIT, S_FIN, S_TOP, S_EMIT
  } seq_state_t;

  seq_state_t          state;
  logic [CNT_W-1:0]    count;
  logic                aborted;
  logic [LIMIT_W-1:0]  stack_limit;
  action_t             tok_action;
  logic                tok_last;
  word_t               y_reg;
  status_t             status_r;
  word_t               value_r;
  logic                refused_r;

  word_t               mem [STACK_DEPTH];
  word_t               rd_data;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  word_t               wr_data;

  logic                in_xfer;
  logic                is_push;
  logic                full;
  logic [LIMIT_W-1:0]  lim1;
  logic                div_zero;
  logic                out_free;
  logic [CNT_W-1:0]    cnt_m1;
  logic [CNT_W-1:0]    cnt_m2;

  alu_req_t            alu_req;
  alu_rsp_t            alu_rsp;

  assign in_ch.ready = (state == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign is_push     = !(in_ch.action inside {ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV});
  assign lim1        = (stack_limit == '0) ? LIMIT_W'(1) : stack_limit;
  assign full        = (CMP_W'(count) >= CMP_W'(lim1)) || (count >= CNT_W'(STACK_DEPTH));
  assign div_zero    = (tok_action == ACT_DIV) && (y_reg == '0);
  assign out_free    = !out_ch.valid || out_ch.ready;
  assign cnt_m1      = count - CNT_W'(1);
  assign cnt_m2      = count - CNT_W'(2);

  assign alu_req.start = (state == S_EXEC) && !div_zero;
  assign alu_req.op    = tok_action;

  pse_alu u_alu (
    .clk    (clk),
    .rst    (rst),
    .req    (alu_req),
    .a      (rd_data),
    .b      (y_reg),
    .rsp    (alu_rsp)
  );

  // stack memory port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = cnt_m1[AW-1:0];
    wr_en   = 1'b0;
    wr_addr = count[AW-1:0];
    wr_data = in_ch.operand;
    case (state)
      S_IDLE: begin
        wr_en = in_xfer && !aborted && is_push && !full;
      end
      S_RD1: rd_en = 1'b1;
      S_RD2: begin
        rd_en   = 1'b1;
        rd_addr = cnt_m2[AW-1:0];
      end
      S_WAIT: begin
        wr_en   = alu_rsp.done;
        wr_addr = cnt_m2[AW-1:0];
        wr_data = alu_rsp.result;
      end
      S_FIN: rd_en = tok_last && !aborted && (count != '0);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stack_limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      stack_limit <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      aborted      <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready && (state != S_EMIT)) begin
        out_ch.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            tok_action <= in_ch.action;
            tok_last   <= in_ch.last;
            status_r   <= ST_OK;
            value_r    <= '0;
            refused_r  <= 1'b0;
            state      <= S_FIN;
            if (aborted) begin
              status_r <= ST_IGNORED;
            end else if (is_push) begin
              if (full) begin
                refused_r <= 1'b1;
              end else begin
                count <= count + CNT_W'(1);
              end
            end else if (count < CNT_W'(2)) begin
              count    <= '0;
              aborted  <= 1'b1;
              status_r <= ST_UNDERFLOW;
            end else begin
              state <= S_RD1;
            end
          end
        end
        S_RD1: state <= S_RD2;
        S_RD2: begin
          y_reg <= rd_data;
          state <= S_EXEC;
        end
        S_EXEC: begin
          if (div_zero) begin
            count    <= cnt_m2;
            aborted  <= 1'b1;
            status_r <= ST_DIVZERO;
            state    <= S_FIN;
          end else begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (alu_rsp.done) begin
            count <= cnt_m1;
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (tok_last && !aborted) begin
            if (count == '0) begin
              value_r  <= '1;
              status_r <= ST_FINAL_OK;
              state    <= S_EMIT;
            end else begin
              state <= S_TOP;
            end
          end else begin
            state <= S_EMIT;
          end
        end
        S_TOP: begin
          value_r  <= rd_data;
          status_r <= (count > CNT_W'(1)) ? ST_FINAL_BAD : ST_FINAL_OK;
          state    <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_ch.valid        <= 1'b1;
            out_ch.status       <= status_r;
            out_ch.value        <= value_r;
            out_ch.push_refused <= refused_r;
            out_ch.done_res     <= tok_last;
            if (tok_last) begin
              count   <= '0;
              aborted <= 1'b0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
